// ----- sv/tmps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the trapezoidal motion profile step core.
// No dependencies.
package tmps_pkg;

    localparam int DIST_FRAC_BITS_DEF = 16;
    localparam int SPEED_WIDTH_DEF    = 32;

    localparam int SPEED_FRAC  = 16;
    localparam int PERIOD_FRAC = 24;
    localparam int GAIN_FRAC   = 8;
    localparam int POS_W       = 40;
    localparam int REM_W       = 41;
    localparam int BASE_W      = 32;
    localparam int GAIN_W      = 16;
    localparam int PERIOD_W    = 24;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 40;

    // input item kinds (code 3 is unused)
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_GAIN  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PATH_LEN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_TGT   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_ACC   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_DEC   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_START_GAIN = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD     = 3'd5;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd256;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd16777;

    typedef enum logic [1:0] {
        ST_STEP     = 2'd0,
        ST_FINISHED = 2'd1,
        ST_IGNORED  = 2'd2,
        ST_ACCEPTED = 2'd3
    } status_t;

    typedef enum logic {
        MODE_MUL = 1'b0,
        MODE_DIV = 1'b1
    } unit_mode_t;

endpackage

// ----- sv/tmps_serial_unit.sv -----
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier and restoring divider sharing one set of registers.
// Depends on tmps_pkg.
module tmps_serial_unit #(
    parameter int OW = 33,
    parameter int NW = 80,
    parameter int DW = 42,
    parameter int RW = 80
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  tmps_pkg::unit_mode_t  mode,
    input  logic [NW-1:0]         opa,     // multiplier (low OW bits) or numerator
    input  logic [DW-1:0]         opb,     // multiplicand or divisor
    output logic                  done,
    output logic [RW-1:0]         result
);
    localparam int CW = $clog2(NW + 1);

    logic                 busy_reg;
    logic                 done_reg;
    tmps_pkg::unit_mode_t mode_reg;
    logic [CW-1:0]        cnt_reg;
    logic [NW-1:0]        sh_reg;
    logic [DW-1:0]        od_reg;
    logic [RW-1:0]        acc_reg;
    logic [DW-1:0]        rem_reg;

    logic          bit_in;
    logic [DW:0]   trial;
    logic [DW:0]   den;
    logic          fits;
    logic [DW:0]   rem_next;
    logic [RW-1:0] addend;

    assign bit_in   = sh_reg[NW-1];
    assign trial    = {rem_reg, bit_in};
    assign den      = {1'b0, od_reg};
    assign fits     = (trial >= den);
    assign rem_next = fits ? (trial - den) : trial;
    assign addend   = bit_in ? {{(RW-DW){1'b0}}, od_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= tmps_pkg::MODE_MUL;
        end else begin
            // pulse on the last bit step
            done_reg <= !start && busy_reg && (cnt_reg == CW'(1));
            if (start) begin
                busy_reg <= 1'b1;
                mode_reg <= mode;
                cnt_reg  <= (mode == tmps_pkg::MODE_MUL) ? CW'(OW) : CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // multiplier bits are consumed MSB first from the top of the shifter
            sh_reg  <= (mode == tmps_pkg::MODE_MUL) ? (opa << (NW - OW)) : opa;
            od_reg  <= opb;
            acc_reg <= '0;
            rem_reg <= '0;
        end else if (busy_reg) begin
            sh_reg <= sh_reg << 1;
            if (mode_reg == tmps_pkg::MODE_MUL) begin
                acc_reg <= (acc_reg << 1) + addend;
            end else begin
                acc_reg <= {acc_reg[RW-2:0], fits};
                rem_reg <= rem_next[DW-1:0];
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ----- sv/trapezoidal_motion_profile_step_core.sv -----
`timescale 1ns / 1ps
// Top level of the trapezoidal motion profile step core: sequencer and profile state.
// Depends on tmps_pkg and tmps_serial_unit.

// One transaction in, one result out. Every product and quotient goes through a single
// bit-serial multiply/divide unit, one bit per cycle, with a multiplier width of OW
// (OW = max(SPEED_WIDTH+1, 32), 33 by default) and a numerator width of NW
// (NW = 2*SPEED_WIDTH+DIST_FRAC_BITS, 80 by default). A start or gain change costs three
// multiplies; a tick in the cruise/ramp region costs three multiplies and, with a nonzero
// decel limit, one divide, plus a second divide on the tick that enters the final region
// while path is left; a tick in the final region costs one or two multiplies. Ignored
// or finished items skip the unit. s_tready is high only while the sequencer is idle;
// the result register lets the next transaction start while a result waits on m_tready.
module trapezoidal_motion_profile_step_core #(
    parameter int DIST_FRAC_BITS = tmps_pkg::DIST_FRAC_BITS_DEF,
    parameter int SPEED_WIDTH    = tmps_pkg::SPEED_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tmps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tmps_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [15:0] new_gain
    input  logic [1:0]                          s_tuser,   // [1:0] op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [39:0] position, then speed, decel_in_use (SPEED_WIDTH each), in_final_region, zero pad
    output logic [((41+2*SPEED_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic [1:0]                          m_tuser    // [1:0] status
);
    localparam int SW      = SPEED_WIDTH;
    localparam int DF      = DIST_FRAC_BITS;
    localparam int SF      = tmps_pkg::SPEED_FRAC;
    localparam int PF      = tmps_pkg::PERIOD_FRAC;
    localparam int GF      = tmps_pkg::GAIN_FRAC;
    localparam int PW      = tmps_pkg::POS_W;
    localparam int BW      = tmps_pkg::BASE_W;
    localparam int OW      = (SW + 1 > 32) ? SW + 1 : 32;
    localparam int NW      = 2 * SW + DF;
    localparam int DW      = (SW + 1 > 42) ? SW + 1 : 42;
    localparam int RW      = (2 * OW > NW) ? 2 * OW : NW;
    localparam int AREA_SH = PF + 1 + SF - DF;
    localparam int M_TDATA_W = ((41 + 2 * SW + 7) / 8) * 8;
    localparam int PAD_W   = M_TDATA_W - (41 + 2 * SW);

    localparam logic [SW-1:0] SPEED_MAX = {SW{1'b1}};
    localparam logic [PW-1:0] POS_MAX   = {PW{1'b1}};
    // twice the largest position
    localparam logic [41:0]   AREA_MAX  = {1'b0, POS_MAX, 1'b0};
    localparam logic [40:0]   REM_MAXV  = {1'b0, {40{1'b1}}};
    localparam logic [40:0]   REM_MINV  = {1'b1, {40{1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_TGT, S_ACC, S_DEC, S_DV, S_NEXT, S_AREA, S_SQ, S_NEED,
        S_ENTER, S_DECEL, S_UPD, S_EMIT
    } state_t;

    // configuration
    logic [PW-1:0]                    path_len_reg;
    logic [BW-1:0]                    base_tgt_reg, base_acc_reg, base_dec_reg;
    logic [tmps_pkg::GAIN_W-1:0]      start_gain_reg;
    logic [tmps_pkg::PERIOD_W-1:0]    period_reg;

    // profile state
    state_t                           state_reg;
    logic                             issued_reg;
    logic                             final_reg;
    logic [PW-1:0]                    trav_reg;
    logic signed [40:0]               rem_reg;
    logic [SW-1:0]                    cur_reg, tgt_reg, acc_lim_reg, dec_lim_reg;
    logic [tmps_pkg::GAIN_W-1:0]      gain_reg;
    logic                             start_mode_reg;
    tmps_pkg::status_t                status_reg;

    // per-tick scratch
    logic [SW-1:0]                    dv_reg, next_reg;
    logic [41:0]                      delta_reg;
    logic [2*SW-1:0]                  sq_reg;
    logic [39:0]                      left_reg;

    logic                             m_tvalid_reg;
    logic [M_TDATA_W-1:0]             m_tdata_reg;
    logic [1:0]                       m_tuser_reg;

    // shared unit hookup
    logic                             u_start, u_done, launch;
    tmps_pkg::unit_mode_t             u_mode;
    logic [NW-1:0]                    u_a;
    logic [DW-1:0]                    u_b;
    logic [RW-1:0]                    u_res;

    logic [SW:0]                      spd_sum;
    logic [SW-1:0]                    scaled, dv_val, next_next;
    logic [SW-1:0]                    sat_base_acc, sat_base_dec;
    logic [SW+BW-1:0]                 ba_w, bd_w;
    logic [RW-1:0]                    q_sh, a_sh;
    logic [41:0]                      area_val;
    logic                             need_enter;
    logic [SW-1:0]                    dec_fit;
    logic signed [42:0]               rem_diff;
    logic [42:0]                      trav_sum;
    logic                             accept;

    assign accept  = s_tvalid && s_tready;
    assign spd_sum = {1'b0, cur_reg} + {1'b0, next_reg};

    always_comb begin
        u_mode = tmps_pkg::MODE_MUL;
        u_a    = '0;
        u_b    = '0;
        launch = 1'b1;
        unique case (state_reg)
            S_TGT:   begin u_a = NW'(gain_reg); u_b = DW'(base_tgt_reg); end
            S_ACC:   begin u_a = NW'(gain_reg); u_b = DW'(base_acc_reg); end
            S_DEC:   begin u_a = NW'(gain_reg); u_b = DW'(base_dec_reg); end
            S_DV: begin
                u_a = NW'(period_reg);
                u_b = final_reg ? DW'(dec_lim_reg) : DW'(acc_lim_reg);
            end
            S_AREA:  begin u_a = NW'(period_reg); u_b = DW'(spd_sum); end
            S_SQ:    begin u_a = NW'(next_reg); u_b = DW'(next_reg); end
            S_NEED: begin
                u_mode = tmps_pkg::MODE_DIV;
                u_a    = {sq_reg, {DF{1'b0}}};
                u_b    = DW'({dec_lim_reg, 1'b0});
            end
            S_DECEL: begin
                u_mode = tmps_pkg::MODE_DIV;
                u_a    = {sq_reg, {DF{1'b0}}};
                u_b    = DW'({left_reg, 1'b0});
            end
            default: launch = 1'b0;
        endcase
    end

    assign u_start = launch && !issued_reg;

    tmps_serial_unit #(
        .OW (OW),
        .NW (NW),
        .DW (DW),
        .RW (RW)
    ) u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (u_start),
        .mode    (u_mode),
        .opa     (u_a),
        .opb     (u_b),
        .done    (u_done),
        .result  (u_res)
    );

    // result decoding
    always_comb begin
        scaled       = (|u_res[RW-1:GF+SW]) ? SPEED_MAX : u_res[GF +: SW];
        dv_val       = u_res[PF +: SW];
        a_sh         = u_res >> AREA_SH;
        area_val     = (a_sh > RW'(AREA_MAX)) ? AREA_MAX : a_sh[41:0];
        q_sh         = u_res >> SF;
        need_enter   = (q_sh > RW'(rem_reg[39:0]));
        dec_fit      = (q_sh > RW'(SPEED_MAX)) ? SPEED_MAX : q_sh[SW-1:0];
        ba_w         = {{SW{1'b0}}, base_acc_reg};
        bd_w         = {{SW{1'b0}}, base_dec_reg};
        sat_base_acc = (ba_w > {{BW{1'b0}}, SPEED_MAX}) ? SPEED_MAX : ba_w[SW-1:0];
        sat_base_dec = (bd_w > {{BW{1'b0}}, SPEED_MAX}) ? SPEED_MAX : bd_w[SW-1:0];
        rem_diff     = {{2{rem_reg[40]}}, rem_reg} - $signed({1'b0, delta_reg});
        trav_sum     = {3'b000, trav_reg} + {1'b0, delta_reg};
        // one acceleration step toward the target, never past it
        if (cur_reg < tgt_reg) begin
            next_next = (dv_reg > tgt_reg - cur_reg) ? tgt_reg : cur_reg + dv_reg;
        end else if (cur_reg > tgt_reg) begin
            next_next = (dv_reg > cur_reg - tgt_reg) ? tgt_reg : cur_reg - dv_reg;
        end else begin
            next_next = cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            issued_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            path_len_reg   <= '0;
            base_tgt_reg   <= '0;
            base_acc_reg   <= '0;
            base_dec_reg   <= '0;
            start_gain_reg <= tmps_pkg::GAIN_RESET;
            period_reg     <= tmps_pkg::PERIOD_RESET;
            final_reg      <= 1'b0;
            trav_reg       <= '0;
            rem_reg        <= '0;
            cur_reg        <= '0;
            tgt_reg        <= '0;
            acc_lim_reg    <= '0;
            dec_lim_reg    <= '0;
            gain_reg       <= tmps_pkg::GAIN_RESET;
            start_mode_reg <= 1'b0;
            status_reg     <= tmps_pkg::ST_STEP;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    tmps_pkg::REG_PATH_LEN:   path_len_reg   <= cfg_wr_data[PW-1:0];
                    tmps_pkg::REG_BASE_TGT:   base_tgt_reg   <= cfg_wr_data[BW-1:0];
                    tmps_pkg::REG_BASE_ACC:   base_acc_reg   <= cfg_wr_data[BW-1:0];
                    tmps_pkg::REG_BASE_DEC:   base_dec_reg   <= cfg_wr_data[BW-1:0];
                    tmps_pkg::REG_START_GAIN: start_gain_reg <= cfg_wr_data[15:0];
                    tmps_pkg::REG_PERIOD:     period_reg     <= cfg_wr_data[23:0];
                    default: ;
                endcase
            end

            // S_EMIT loads the result register itself
            if (m_tready && state_reg != S_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end

            if (u_start) begin
                issued_reg <= 1'b1;
            end else if (u_done) begin
                issued_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (s_tuser == tmps_pkg::OP_START) begin
                            final_reg      <= 1'b0;
                            trav_reg       <= '0;
                            rem_reg        <= {1'b0, path_len_reg};
                            cur_reg        <= '0;
                            gain_reg       <= start_gain_reg;
                            start_mode_reg <= 1'b1;
                            state_reg      <= S_TGT;
                        end else if (s_tuser == tmps_pkg::OP_GAIN && !final_reg) begin
                            gain_reg       <= s_tdata;
                            start_mode_reg <= 1'b0;
                            state_reg      <= S_TGT;
                        end else if (s_tuser == tmps_pkg::OP_TICK) begin
                            if (rem_reg[40] || rem_reg == '0) begin
                                status_reg <= tmps_pkg::ST_FINISHED;
                                state_reg  <= S_EMIT;
                            end else begin
                                state_reg <= S_DV;
                            end
                        end else begin
                            // gain change in the final region, or the unused code
                            status_reg <= tmps_pkg::ST_IGNORED;
                            state_reg  <= S_EMIT;
                        end
                    end
                end
                S_TGT: begin
                    if (u_done) begin
                        tgt_reg   <= scaled;
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (u_done) begin
                        acc_lim_reg <= (!start_mode_reg && gain_reg == '0) ? sat_base_acc : scaled;
                        state_reg   <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (u_done) begin
                        dec_lim_reg <= (!start_mode_reg && gain_reg == '0) ? sat_base_dec : scaled;
                        status_reg  <= tmps_pkg::ST_ACCEPTED;
                        state_reg   <= S_EMIT;
                    end
                end
                S_DV: begin
                    if (u_done) begin
                        dv_reg <= dv_val;
                        if (!final_reg) begin
                            state_reg <= S_NEXT;
                        end else if (dv_val > cur_reg) begin
                            // speed would go negative: stop and take all that is left
                            next_reg  <= '0;
                            delta_reg <= {1'b0, rem_reg};
                            state_reg <= S_UPD;
                        end else begin
                            next_reg  <= cur_reg - dv_val;
                            state_reg <= S_AREA;
                        end
                    end
                end
                S_NEXT: begin
                    next_reg  <= next_next;
                    state_reg <= S_AREA;
                end
                S_AREA: begin
                    if (u_done) begin
                        delta_reg <= area_val;
                        state_reg <= final_reg ? S_UPD : S_SQ;
                    end
                end
                S_SQ: begin
                    if (u_done) begin
                        sq_reg <= u_res[2*SW-1:0];
                        if (dec_lim_reg != '0) begin
                            state_reg <= S_NEED;
                        end else begin
                            state_reg <= (next_reg != '0) ? S_ENTER : S_UPD;
                        end
                    end
                end
                S_NEED: begin
                    if (u_done) begin
                        state_reg <= need_enter ? S_ENTER : S_UPD;
                    end
                end
                S_ENTER: begin
                    tgt_reg   <= '0;
                    final_reg <= 1'b1;
                    if (rem_diff[42] || rem_diff == '0) begin
                        dec_lim_reg <= SPEED_MAX;
                        state_reg   <= S_UPD;
                    end else begin
                        left_reg  <= rem_diff[39:0];
                        state_reg <= S_DECEL;
                    end
                end
                S_DECEL: begin
                    if (u_done) begin
                        dec_lim_reg <= dec_fit;
                        state_reg   <= S_UPD;
                    end
                end
                S_UPD: begin
                    trav_reg <= (trav_sum > {3'b000, POS_MAX}) ? POS_MAX : trav_sum[PW-1:0];
                    if (rem_diff[42:40] == 3'b000 || rem_diff[42:40] == 3'b111) begin
                        rem_reg <= rem_diff[40:0];
                    end else begin
                        rem_reg <= rem_diff[42] ? REM_MINV : REM_MAXV;
                    end
                    cur_reg    <= next_reg;
                    status_reg <= tmps_pkg::ST_STEP;
                    state_reg  <= S_EMIT;
                end
                S_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{PAD_W{1'b0}}, final_reg, dec_lim_reg, cur_reg,
                                         trav_reg};
                        m_tuser_reg  <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- sv/tmps_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the trapezoidal motion profile step core, bound to the top level.
// Depends on trapezoidal_motion_profile_step_core.
module tmps_checker #(
    parameter int M_TDATA_W = 112
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // one transaction at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready stayed high after an accepted transaction");

    // no result can appear in the cycle right after an accept
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after accept");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind trapezoidal_motion_profile_step_core tmps_checker #(
    .M_TDATA_W (M_TDATA_W)
) u_tmps_checker (.*);

// ----- test/tb_trapezoidal_motion_profile_step_core.sv -----
`timescale 1ns / 1ps
// Self-checking bench for trapezoidal_motion_profile_step_core: paths, ticks and gain changes
// are checked against a built-in fixed-point profile predictor. Depends on tmps_pkg and the core.
module tb_trapezoidal_motion_profile_step_core;
    import tmps_pkg::*;

    localparam int TDATA_W = ((41 + 2 * 32 + 7) / 8) * 8;
    localparam logic [39:0] POS_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] SPD_MAX = 32'hFFFF_FFFF;
    localparam logic [1:0]  OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] gain;
    } cmd_t;

    typedef struct packed {
        logic [39:0] position;
        logic [31:0] speed;
        logic [31:0] decel;
        logic        final_rgn;
        logic [1:0]  status;
    } prof_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    trapezoidal_motion_profile_step_core DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr),
        .cfg_wr_data(cfg_wr_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // predictor copies of configuration and state
    logic [39:0] c_len;
    logic [31:0] c_tgt, c_acc, c_dec;
    logic [15:0] c_sgain;
    logic [23:0] c_period;
    logic        p_final;
    logic [39:0] p_trav;
    logic signed [63:0] p_rem;
    logic [31:0] p_speed, p_target, p_accel, p_decel;
    logic [15:0] p_gain;

    cmd_t  cmd_q[$];
    prof_t profile_q[$];
    int    errors = 0;
    int    tx_gap = 0;
    int    rx_gap = 0;
    bit    quiet = 0;
    bit    hold_go = 0;
    bit    hold_rx = 0;
    longint cycles = 0;

    function automatic logic [31:0] scale(logic [31:0] b, logic [15:0] g);
        logic [63:0] v;
        v = ({32'd0, b} * {48'd0, g}) >> GAIN_FRAC;
        return (v > SPD_MAX) ? SPD_MAX : v[31:0];
    endfunction

    function automatic logic [40:0] trapezoid(logic [31:0] v0, logic [31:0] v1);
        logic [127:0] p;
        p = ({96'd0, v0} + {96'd0, v1}) * {104'd0, c_period};
        p = p >> (PERIOD_FRAC + 1 + SPEED_FRAC - 16);
        return (p > {POS_MAX, 1'b0}) ? {POS_MAX, 1'b0} : p[40:0];
    endfunction

    function automatic logic [31:0] rate_dv(logic [31:0] r);
        logic [63:0] p;
        p = ({32'd0, r} * {40'd0, c_period}) >> PERIOD_FRAC;
        return p[31:0];
    endfunction

    function automatic prof_t snap(status_t st);
        prof_t r;
        r.position = p_trav;
        r.speed = p_speed;
        r.decel = p_decel;
        r.final_rgn = p_final;
        r.status = st;
        return r;
    endfunction

    function automatic prof_t profile_step(cmd_t c);
        logic [31:0] dv, nxt;
        logic [40:0] delta;
        logic [127:0] need, dq;
        logic signed [63:0] left, r;
        logic enter;
        if (c.op == OP_START) begin
            p_final = 0; p_trav = 0; p_rem = {24'd0, c_len}; p_speed = 0;
            p_gain = c_sgain;
            p_target = scale(c_tgt, p_gain);
            p_accel = scale(c_acc, p_gain);
            p_decel = scale(c_dec, p_gain);
            return snap(ST_ACCEPTED);
        end
        if (c.op == OP_GAIN) begin
            if (p_final) return snap(ST_IGNORED);
            p_gain = c.gain;
            p_target = scale(c_tgt, p_gain);
            if (p_gain == 0) begin
                p_accel = c_acc; p_decel = c_dec;
            end else begin
                p_accel = scale(c_acc, p_gain); p_decel = scale(c_dec, p_gain);
            end
            return snap(ST_ACCEPTED);
        end
        if (c.op != OP_TICK) return snap(ST_IGNORED);
        if (p_rem <= 0) return snap(ST_FINISHED);
        if (!p_final) begin
            dv = rate_dv(p_accel);
            if (p_speed < p_target)
                nxt = (dv > p_target - p_speed) ? p_target : p_speed + dv;
            else if (p_speed > p_target)
                nxt = (dv > p_speed - p_target) ? p_target : p_speed - dv;
            else
                nxt = p_speed;
            delta = trapezoid(p_speed, nxt);
            if (p_decel == 0) begin
                enter = nxt != 0;
            end else begin
                need = (({96'd0, nxt} * {96'd0, nxt}) << 16) / {95'd0, p_decel, 1'b0};
                need = need >> SPEED_FRAC;
                enter = need > p_rem;
            end
            if (enter) begin
                left = p_rem - $signed({23'd0, delta});
                p_target = 0;
                p_final = 1;
                if (left <= 0) begin
                    p_decel = SPD_MAX;
                end else begin
                    dq = (({96'd0, nxt} * {96'd0, nxt}) << 16) / {63'd0, left, 1'b0};
                    dq = dq >> SPEED_FRAC;
                    p_decel = (dq > SPD_MAX) ? SPD_MAX : dq[31:0];
                end
            end
        end else begin
            dv = rate_dv(p_decel);
            if (dv > p_speed) begin
                nxt = 0;
                delta = p_rem[40:0];
            end else begin
                nxt = p_speed - dv;
                delta = trapezoid(p_speed, nxt);
            end
        end
        p_trav = ({1'b0, delta} > {1'b0, POS_MAX - p_trav}) ? POS_MAX : p_trav + delta[39:0];
        r = p_rem - $signed({23'd0, delta});
        if (r < -(64'sd1 <<< 40)) r = -(64'sd1 <<< 40);
        p_rem = r;
        p_speed = nxt;
        return snap(ST_STEP);
    endfunction

    // driver
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!s_tvalid || s_tready) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_tvalid <= 0;
            end else if (cmd_q.size() > 0 && (quiet || $urandom_range(0, 5) != 0)) begin
                cmd_t c;
                c = cmd_q.pop_front();
                profile_q.push_back(profile_step(c));
                s_tvalid <= 1;
                s_tuser <= c.op;
                s_tdata <= c.gain;
            end else begin
                s_tvalid <= 0;
                // idle burst before the next item is offered
                if (cmd_q.size() > 0) tx_gap <= $urandom_range(0, 3);
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            prof_t exp_r, got;
            got = {m_tdata[39:0], m_tdata[71:40], m_tdata[103:72], m_tdata[104], m_tuser};
            if (profile_q.size() == 0) begin
                $error("unexpected result transaction");
                errors = errors + 1;
            end else begin
                exp_r = profile_q.pop_front();
                if (got.position !== exp_r.position) begin
                    $error("position exp %h got %h", exp_r.position, got.position);
                    errors = errors + 1;
                end
                if (got.speed !== exp_r.speed) begin
                    $error("speed exp %h got %h", exp_r.speed, got.speed);
                    errors = errors + 1;
                end
                if (got.decel !== exp_r.decel) begin
                    $error("decel_in_use exp %h got %h", exp_r.decel, got.decel);
                    errors = errors + 1;
                end
                if (got.final_rgn !== exp_r.final_rgn) begin
                    $error("in_final_region exp %b got %b", exp_r.final_rgn, got.final_rgn);
                    errors = errors + 1;
                end
                if (got.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, got.status);
                    errors = errors + 1;
                end
            end
        end
        if (hold_rx) begin
            m_tready <= 0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_tready <= 0;
        end else if (quiet || $urandom_range(0, 4) != 0) begin
            m_tready <= 1;
        end else begin
            m_tready <= 0;
            rx_gap <= $urandom_range(0, 3);
        end
    end

    // long receiver hold-off, timed here
    initial begin
        wait (hold_go);
        hold_rx = 1;
        repeat (600) @(posedge aclk);
        hold_rx = 0;
    end

    initial begin
        int timeout;
        timeout = 2000000;
        forever begin
            @(posedge aclk);
            if (cycles > timeout) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        cfg_wr_en <= 1;
        cfg_addr <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            REG_PATH_LEN:   c_len = v[39:0];
            REG_BASE_TGT:   c_tgt = v[31:0];
            REG_BASE_ACC:   c_acc = v[31:0];
            REG_BASE_DEC:   c_dec = v[31:0];
            REG_START_GAIN: c_sgain = v[15:0];
            REG_PERIOD:     c_period = v[23:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || s_tvalid || profile_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic push(logic [1:0] op, logic [15:0] g);
        cmd_t c;
        c.op = op;
        c.gain = g;
        cmd_q.push_back(c);
    endtask

    // random path with mostly ticks, so the profile runs to its end
    task automatic random_path(int n);
        push(OP_START, 16'd0);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0: push(OP_GAIN, 16'($urandom));
                1: push(OP_GAIN, $urandom_range(0, 1) ? 16'd0 : 16'hFFFF);
                2: push(OP_UNUSED, 16'($urandom));
                3: push(OP_START, 16'($urandom));
                default: push(OP_TICK, 16'($urandom));
            endcase
        end
    endtask

    task automatic random_cfg();
        cfg_write(REG_PATH_LEN,
                  {8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64)),
                   32'($urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom)});
        cfg_write(REG_BASE_TGT, CFG_DATA_W'($urandom_range(0, 2) == 0 ? $urandom
                                                                    : $urandom_range(0, 1 << 22)));
        cfg_write(REG_BASE_ACC, CFG_DATA_W'($urandom_range(0, 2) == 0 ? $urandom
                                                                    : $urandom_range(0, 1 << 24)));
        cfg_write(REG_BASE_DEC, CFG_DATA_W'($urandom_range(0, 5) == 0 ? 32'd0
                                                                    : $urandom_range(0, 1 << 24)));
        cfg_write(REG_START_GAIN, CFG_DATA_W'($urandom_range(0, 5) == 0 ? $urandom
                                                                      : $urandom_range(0, 512)));
        cfg_write(REG_PERIOD, CFG_DATA_W'($urandom_range(0, 3) == 0
                                          ? $urandom_range(1, 24'hFF_FFFF)
                                          : $urandom_range(1000, 200000)));
    endtask

    initial begin
        c_len = 0; c_tgt = 0; c_acc = 0; c_dec = 0;
        c_sgain = GAIN_RESET; c_period = PERIOD_RESET;
        p_final = 0; p_trav = 0; p_rem = 0; p_speed = 0; p_target = 0;
        p_accel = 0; p_decel = 0; p_gain = GAIN_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: tick with no path, unused op, gain change, a short ordinary path
        push(OP_TICK, 16'd0);
        push(OP_UNUSED, 16'hFFFF);
        push(OP_GAIN, 16'd0);
        drain();
        cfg_write(REG_PATH_LEN, 40'h00_0010_0000);
        cfg_write(REG_BASE_TGT, CFG_DATA_W'(32'h0010_0000));
        cfg_write(REG_BASE_ACC, CFG_DATA_W'(32'h0100_0000));
        cfg_write(REG_BASE_DEC, CFG_DATA_W'(32'h0000_0000));
        cfg_write(REG_START_GAIN, CFG_DATA_W'(16'h0100));
        cfg_write(REG_PERIOD, CFG_DATA_W'(24'd16777));
        push(OP_START, 16'd0);
        push(OP_GAIN, 16'hFFFF);
        push(OP_GAIN, 16'd0);
        push(OP_GAIN, 16'h0100);
        repeat (8) push(OP_TICK, 16'd0);
        push(OP_GAIN, 16'h0080);
        drain();
        // extremes: huge path and rates, gain zero at start, zero path
        cfg_write(REG_PATH_LEN, {CFG_DATA_W{1'b1}});
        cfg_write(REG_BASE_TGT, CFG_DATA_W'(32'hFFFF_FFFF));
        cfg_write(REG_BASE_ACC, CFG_DATA_W'(32'hFFFF_FFFF));
        cfg_write(REG_BASE_DEC, CFG_DATA_W'(32'hFFFF_FFFF));
        cfg_write(REG_PERIOD, CFG_DATA_W'(24'hFF_FFFF));
        push(OP_START, 16'd0);
        repeat (4) push(OP_TICK, 16'd0);
        drain();
        cfg_write(REG_START_GAIN, CFG_DATA_W'(16'd0));
        push(OP_START, 16'd0);
        push(OP_TICK, 16'd0);
        drain();
        cfg_write(REG_PATH_LEN, 40'd0);
        push(OP_START, 16'd0);
        push(OP_TICK, 16'd0);
        drain();

        // receiver holds off while the sender keeps offering
        hold_go = 1;
        random_cfg();
        random_path(12);
        drain();

        for (int k = 0; k < 26; k++) begin
            if (k == 22) quiet = 1;
            random_cfg();
            random_path(30);
            drain();
        end

        repeat (50) @(posedge aclk);
        if (errors == 0 && profile_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
